// File: sv/assert_macros.svh
// assertion macros used by the anchored_spring_force rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: sv/asf_pkg.sv
// types and constants of the anchored spring force pipeline
package asf_pkg;

    localparam int SQRT_STEPS = 34;
    localparam int DIV_STEPS  = 17;

    localparam logic [33:0] MIN_DIST  = 34'd66;
    localparam logic [47:0] MAG_CLAMP = 48'h8000_0000_0000;

    localparam logic [1:0] REG_STIFFNESS = 2'd0;
    localparam logic [1:0] REG_REST_LEN  = 2'd1;
    localparam logic [1:0] REG_PULL_ONLY = 2'd2;

    // sideband through the square root
    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][32:0] mag;
    } asf_vec_t;

    // sideband through the divider
    typedef struct packed {
        logic [2:0]  neg;
        logic        diffneg;
        logic        skip;
        logic [47:0] m;
    } asf_frc_t;

endpackage

// File: sv/asf_sqrt.sv
// pipelined integer square root, one result bit per stage
module asf_sqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [67:0]         in_rad,
    input  asf_pkg::asf_vec_t   in_side,
    output logic                out_valid,
    output logic [33:0]         out_root,
    output asf_pkg::asf_vec_t   out_side
);

    localparam int N = asf_pkg::SQRT_STEPS;

    logic              vld_reg  [0:N];
    logic [67:0]       rad_reg  [0:N];
    logic [36:0]       rem_reg  [0:N];
    logic [33:0]       root_reg [0:N];
    asf_pkg::asf_vec_t side_reg [0:N];

    assign vld_reg[0]  = in_valid;
    assign rad_reg[0]  = in_rad;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign side_reg[0] = in_side;

    for (genvar k = 1; k <= N; k++) begin : g_step
        logic [36:0] cur;
        logic [36:0] trial;
        logic [36:0] rem_next;
        logic [33:0] root_next;

        always_comb begin
            cur   = {rem_reg[k-1][34:0], rad_reg[k-1][67:66]};
            trial = {1'b0, root_reg[k-1], 2'b01};
            if (cur >= trial) begin
                rem_next  = cur - trial;
                root_next = {root_reg[k-1][32:0], 1'b1};
            end else begin
                rem_next  = cur;
                root_next = {root_reg[k-1][32:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (en) begin
                rad_reg[k]  <= {rad_reg[k-1][65:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_root  = root_reg[N];
    assign out_side  = side_reg[N];

endmodule

// File: sv/asf_div.sv
// pipelined restoring divider for the three unit vector components
module asf_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2:0][32:0]    in_mag,
    input  logic [33:0]         in_den,
    input  asf_pkg::asf_frc_t   in_side,
    output logic                out_valid,
    output logic [2:0][16:0]    out_quo,
    output asf_pkg::asf_frc_t   out_side
);

    localparam int N = asf_pkg::DIV_STEPS;

    logic              vld_reg  [0:N];
    logic [2:0][33:0]  rem_reg  [0:N];
    logic [2:0][16:0]  lo_reg   [0:N];
    logic [2:0][16:0]  quo_reg  [0:N];
    logic [33:0]       den_reg  [0:N];
    asf_pkg::asf_frc_t side_reg [0:N];

    // numerator is mag shifted up by 16, quotient never exceeds 17 bits
    for (genvar a = 0; a < 3; a++) begin : g_init
        assign rem_reg[0][a] = {2'b00, in_mag[a][32:1]};
        assign lo_reg[0][a]  = {in_mag[a][0], 16'd0};
        assign quo_reg[0][a] = '0;
    end
    assign vld_reg[0]  = in_valid;
    assign den_reg[0]  = in_den;
    assign side_reg[0] = in_side;

    for (genvar k = 1; k <= N; k++) begin : g_step
        logic [2:0][33:0] rem_next;
        logic [2:0][16:0] quo_next;

        for (genvar a = 0; a < 3; a++) begin : g_axis
            logic [34:0] cur;
            always_comb begin
                cur = {rem_reg[k-1][a], lo_reg[k-1][a][16]};
                if (cur >= {1'b0, den_reg[k-1]}) begin
                    rem_next[a] = 34'(cur - {1'b0, den_reg[k-1]});
                    quo_next[a] = {quo_reg[k-1][a][15:0], 1'b1};
                end else begin
                    rem_next[a] = cur[33:0];
                    quo_next[a] = {quo_reg[k-1][a][15:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                for (int a = 0; a < 3; a++) begin
                    lo_reg[k][a] <= {lo_reg[k-1][a][15:0], 1'b0};
                end
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_quo   = quo_reg[N];
    assign out_side  = side_reg[N];

endmodule

// File: sv/anchored_spring_force.sv
// throughput: one item per cycle, the pipeline advances whenever the output register is free
// the square root takes 34 stages and the unit vector divider 17 stages
// a stalled output freezes every stage at once, nothing is dropped or repeated
// synchronous active-low reset clears valid bits and loads the default spring registers
`include "assert_macros.svh"

module anchored_spring_force (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // anchor_x, anchor_y, anchor_z, particle_x, particle_y, particle_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // force_x, force_y, force_z
    output logic [95:0]  m_tdata,
    // force_applied
    output logic [0:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [30:0]  cfg_wr_data
);

    logic [30:0] stiff_reg;
    logic [30:0] rest_reg;
    logic        pull_only_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff_reg     <= 31'd327680;
            rest_reg      <= 31'd131072;
            pull_only_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                asf_pkg::REG_STIFFNESS: stiff_reg     <= cfg_wr_data;
                asf_pkg::REG_REST_LEN:  rest_reg      <= cfg_wr_data;
                asf_pkg::REG_PULL_ONLY: pull_only_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // stage a: deltas
    logic              a_valid_reg;
    asf_pkg::asf_vec_t a_vec_reg;
    asf_pkg::asf_vec_t a_vec_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [32:0] d;
            d = {s_tdata[96 + 32*i + 31], s_tdata[96 + 32*i +: 32]}
              - {s_tdata[32*i + 31], s_tdata[32*i +: 32]};
            a_vec_next.neg[i] = d[32];
            a_vec_next.mag[i] = d[32] ? 33'(~d + 33'd1) : d;
        end
    end

    // stage b: squares, stage c: sum
    logic              b_valid_reg, c_valid_reg;
    logic [2:0][65:0]  b_sq_reg;
    asf_pkg::asf_vec_t b_vec_reg, c_vec_reg;
    logic [65:0]       c_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
        if (en) begin
            a_vec_reg <= a_vec_next;
            for (int i = 0; i < 3; i++) begin
                b_sq_reg[i] <= {33'd0, a_vec_reg.mag[i]} * {33'd0, a_vec_reg.mag[i]};
            end
            b_vec_reg <= a_vec_reg;
            c_sum_reg <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
            c_vec_reg <= b_vec_reg;
        end
    end

    logic              sq_valid;
    logic [33:0]       sq_root;
    asf_pkg::asf_vec_t sq_vec;

    asf_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_rad    ({2'b00, c_sum_reg}),
        .in_side   (c_vec_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_vec)
    );

    // stage d: skip test and spring magnitude partial products
    logic              d_valid_reg, d_skip_reg, d_diffneg_reg;
    logic [47:0]       d_pp_lo_reg, d_pp_hi_reg;
    logic [33:0]       d_dist_reg;
    asf_pkg::asf_vec_t d_vec_reg;
    logic              d_skip_next, d_diffneg_next;
    logic [33:0]       d_diffmag;

    always_comb begin
        if (pull_only_reg) begin
            d_skip_next = sq_root < {3'd0, rest_reg};
        end else begin
            d_skip_next = sq_root < asf_pkg::MIN_DIST;
        end
        if (sq_root == '0) begin
            d_skip_next = 1'b1;
        end
        d_diffneg_next = sq_root > {3'd0, rest_reg};
        d_diffmag = d_diffneg_next ? sq_root - {3'd0, rest_reg}
                                   : {3'd0, rest_reg} - sq_root;
    end

    // stage e: spring magnitude
    logic              e_valid_reg;
    asf_pkg::asf_frc_t e_frc_reg;
    logic [33:0]       e_dist_reg;
    logic [2:0][32:0]  e_mag_reg;
    logic [64:0]       e_prod;
    logic [47:0]       e_m_next;

    always_comb begin
        e_prod   = {17'd0, d_pp_lo_reg} + {d_pp_hi_reg, 17'd0};
        e_m_next = (e_prod[64:16] > {1'b0, asf_pkg::MAG_CLAMP}) ? asf_pkg::MAG_CLAMP
                                                               : e_prod[63:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= sq_valid;
            e_valid_reg <= d_valid_reg;
        end
        if (en) begin
            d_skip_reg    <= d_skip_next;
            d_diffneg_reg <= d_diffneg_next;
            d_pp_lo_reg   <= {31'd0, d_diffmag[16:0]} * {17'd0, stiff_reg};
            d_pp_hi_reg   <= {31'd0, d_diffmag[33:17]} * {17'd0, stiff_reg};
            d_dist_reg    <= sq_root;
            d_vec_reg     <= sq_vec;
            e_frc_reg.neg     <= d_vec_reg.neg;
            e_frc_reg.diffneg <= d_diffneg_reg;
            e_frc_reg.skip    <= d_skip_reg;
            e_frc_reg.m       <= e_m_next;
            e_dist_reg    <= d_dist_reg;
            e_mag_reg     <= d_vec_reg.mag;
        end
    end

    logic              dv_valid;
    logic [2:0][16:0]  dv_quo;
    asf_pkg::asf_frc_t dv_frc;

    asf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (e_valid_reg),
        .in_mag    (e_mag_reg),
        .in_den    (e_dist_reg),
        .in_side   (e_frc_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_frc)
    );

    // stage f: force partial products, stage g: output register
    logic              f_valid_reg;
    logic [2:0][40:0]  f_pl_reg, f_ph_reg;
    asf_pkg::asf_frc_t f_frc_reg;
    logic [95:0]       out_data_reg, out_data_next;
    logic              out_applied_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [64:0] f;
            logic [48:0] fm;
            logic        fneg;
            f    = {24'd0, f_pl_reg[i]} + {f_ph_reg[i], 24'd0};
            fm   = f[64:16];
            fneg = (f_frc_reg.diffneg != f_frc_reg.neg[i]) && (fm != '0);
            if (f_frc_reg.skip) begin
                out_data_next[32*i +: 32] = '0;
            end else if (fneg) begin
                if (fm > 49'h0_0000_8000_0000) begin
                    fm = 49'h0_0000_8000_0000;
                end
                out_data_next[32*i +: 32] = 32'(33'd0 - fm[32:0]);
            end else begin
                if (fm > 49'h0_0000_7FFF_FFFF) begin
                    fm = 49'h0_0000_7FFF_FFFF;
                end
                out_data_next[32*i +: 32] = fm[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg   <= dv_valid;
            out_valid_reg <= f_valid_reg;
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                f_pl_reg[i] <= {17'd0, dv_frc.m[23:0]} * {24'd0, dv_quo[i]};
                f_ph_reg[i] <= {17'd0, dv_frc.m[47:24]} * {24'd0, dv_quo[i]};
            end
            f_frc_reg       <= dv_frc;
            out_data_reg    <= out_data_next;
            out_applied_reg <= !f_frc_reg.skip;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_applied_reg;

    `ASSERT_CLK(a_skip_zero, aclk, aresetn, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    `ASSERT_CLK(a_hold_on_stall, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid)
    `ASSERT_CLK(a_pull_write, aclk, aresetn,
        (cfg_wr_en && cfg_addr == asf_pkg::REG_PULL_ONLY) |=> (pull_only_reg == $past(cfg_wr_data[0])))
    `ASSERT_NEVER(a_no_accept_in_stall, aclk, aresetn, s_tready && m_tvalid && !m_tready)

endmodule

// File: test/anchored_spring_force_tb.sv
// testbench of the anchored spring force pipeline: predicted forces checked per item
module anchored_spring_force_tb;

    typedef struct {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic        applied;
    } force_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [95:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wr_en = 0;
    logic [1:0]   cfg_addr = '0;
    logic [30:0]  cfg_wr_data = '0;

    logic [30:0]  stiffness = 31'd327680;
    logic [30:0]  rest_len = 31'd131072;
    logic         pull = 0;

    force_t       expected_forces[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    anchored_spring_force uut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] sat_force(logic [127:0] f, logic fneg);
        if (f == 0) return 32'd0;
        if (fneg) begin
            if (f > 128'h8000_0000) f = 128'h8000_0000;
            return 32'(-f);
        end
        if (f > 128'h7fff_ffff) f = 128'h7fff_ffff;
        return f[31:0];
    endfunction

    function automatic force_t spring_force(logic [191:0] d);
        force_t       r;
        logic [63:0]  mag[3];
        logic         neg[3];
        logic [127:0] sum, c, distance, diffmag, p, m, u, f;
        logic         diffneg, skip;
        longint       dl;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            dl = longint'($signed(d[96+32*i +: 32])) - longint'($signed(d[32*i +: 32]));
            neg[i] = dl < 0;
            mag[i] = neg[i] ? 64'(-dl) : 64'(dl);
            sum += 128'(mag[i]) * 128'(mag[i]);
        end
        distance = 0;
        for (int b = 40; b >= 0; b--) begin
            c = distance | (128'd1 << b);
            if (c * c <= sum) distance = c;
        end
        skip = pull ? (distance < rest_len) : (distance < 66);
        if (distance == 0) skip = 1;
        r = '{0, 0, 0, 0};
        if (skip) return r;
        diffneg = distance > rest_len;
        diffmag = diffneg ? distance - rest_len : rest_len - distance;
        p = diffmag * stiffness;
        m = p >> 16;
        if (m > (128'd1 << 47)) m = 128'd1 << 47;
        for (int i = 0; i < 3; i++) begin
            u = (128'(mag[i]) << 16) / distance;
            f = (m * u) >> 16;
            if (i == 0) r.fx = sat_force(f, diffneg != neg[i]);
            if (i == 1) r.fy = sat_force(f, diffneg != neg[i]);
            if (i == 2) r.fz = sat_force(f, diffneg != neg[i]);
        end
        r.applied = 1;
        return r;
    endfunction

    always @(posedge aclk) begin
        force_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_forces.size() == 0) begin
                $error("unexpected item");
                fail_count++;
            end else begin
                e = expected_forces.pop_front();
                if (m_tdata[31:0] !== e.fx) begin
                    $error("force_x exp %h got %h", e.fx, m_tdata[31:0]); fail_count++;
                end
                if (m_tdata[63:32] !== e.fy) begin
                    $error("force_y exp %h got %h", e.fy, m_tdata[63:32]); fail_count++;
                end
                if (m_tdata[95:64] !== e.fz) begin
                    $error("force_z exp %h got %h", e.fz, m_tdata[95:64]); fail_count++;
                end
                if (m_tuser[0] !== e.applied) begin
                    $error("force_applied exp %b got %b", e.applied, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(logic [191:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_forces.push_back(spring_force(d));
        @(negedge aclk);
    endtask

    task automatic send_pair(logic [31:0] ax, ay, az, px, py, pz);
        send_item({pz, py, px, az, ay, ax});
    endtask

    task automatic drain;
        s_tvalid <= 0;
        while (expected_forces.size() != 0) @(negedge aclk);
        repeat (70) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] v);
        drain();
        cfg_wr_en <= 1;
        cfg_addr <= idx;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            asf_pkg::REG_STIFFNESS: stiffness = v;
            asf_pkg::REG_REST_LEN:  rest_len = v;
            default:                pull = v[0];
        endcase
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000);
            2: return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return 32'($signed($urandom_range(40000000)) - 20000000);
        endcase
    endfunction

    task automatic test_directed;
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 65, 0, 0);
        send_pair(0, 0, 0, 66, 0, 0);
        send_pair(0, 0, 0, 0, 0, 131072);
        send_pair(0, 0, 0, 0, 65536, 0);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_pair(32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000, 0, 32'h7fff_ffff);
        send_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0);
        send_pair(100, -200, 300, -400, 500, -600);
        write_reg(asf_pkg::REG_PULL_ONLY, 31'd1);
        send_pair(0, 0, 0, 131071, 0, 0);
        send_pair(0, 0, 0, 131072, 0, 0);
        send_pair(0, 0, 0, 0, -300000, 0);
        write_reg(asf_pkg::REG_REST_LEN, 31'd0);
        send_pair(5, 5, 5, 5, 5, 5);
        send_pair(0, 0, 0, 1, 0, 0);
        write_reg(asf_pkg::REG_STIFFNESS, 31'h7fff_ffff);
        write_reg(asf_pkg::REG_REST_LEN, 31'h7fff_ffff);
        write_reg(asf_pkg::REG_PULL_ONLY, 31'd0);
        send_pair(0, 0, 0, 1000, 0, 0);
        send_pair(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0);
        write_reg(asf_pkg::REG_STIFFNESS, 31'd0);
        send_pair(0, 0, 0, 1000, 2000, 0);
    endtask

    task automatic test_random(int n, int s_idle, int r_stall);
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) begin
                write_reg(asf_pkg::REG_STIFFNESS,
                          $urandom_range(7) == 0 ? 31'($urandom)
                                                 : 31'($urandom_range(2000000)));
                write_reg(asf_pkg::REG_REST_LEN,
                          $urandom_range(7) == 0 ? 31'($urandom)
                                                 : 31'($urandom_range(500000)));
                write_reg(asf_pkg::REG_PULL_ONLY, 31'($urandom_range(1)));
            end
            send_pair(rnd_coord(), rnd_coord(), rnd_coord(),
                      rnd_coord(), rnd_coord(), rnd_coord());
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        test_directed();
        test_random(580, 30, 65);
        test_random(580, 65, 30);
        test_random(580, 0, 0);
        drain();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
